// ----- rtl/tsa_pkg.sv -----
// ----------------------------------------------------------------------------
// TDMA slot allocator package
// Sizes, action and status codes, configuration register indexes, and the
// record and command types shared by the allocator's modules.
// ----------------------------------------------------------------------------
package tsa_pkg;

   // Table and log depths.
   localparam int TABLE_ENTRIES = 64;
   localparam int LOG_ENTRIES   = 64;
   localparam int TAB_AW = $clog2(TABLE_ENTRIES);
   localparam int TAB_CW = $clog2(TABLE_ENTRIES + 1);
   localparam int LOG_AW = $clog2(LOG_ENTRIES);
   localparam int LOG_CW = $clog2(LOG_ENTRIES + 1);

   // Field widths.
   localparam int ACT_W     = 2;
   localparam int ID_W      = 27;
   localparam int TIME_W    = 32;
   localparam int STAT_W    = 2;
   localparam int CFG_W     = 16;
   localparam int CSR_IDX_W = 1;

   // Remainder unit: one dividend bit per step.
   localparam int DIV_STEPS = TIME_W;
   localparam int DIV_CW    = $clog2(DIV_STEPS + 1);

   // Action codes.
   localparam logic [ACT_W-1:0] ACT_REQUEST = 2'd0;
   localparam logic [ACT_W-1:0] ACT_REMOVE  = 2'd1;
   localparam logic [ACT_W-1:0] ACT_FRAME   = 2'd2;

   // Status codes.
   localparam logic [STAT_W-1:0] STAT_OK         = 2'd0;
   localparam logic [STAT_W-1:0] STAT_TABLE_FULL = 2'd1;
   localparam logic [STAT_W-1:0] STAT_LOG_FULL   = 2'd2;
   localparam logic [STAT_W-1:0] STAT_NOT_FOUND  = 2'd3;

   // Configuration register indexes and reset values.
   localparam logic [CSR_IDX_W-1:0] CSR_SLOT_LENGTH  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_PERIOD = 1'b1;
   localparam logic [CFG_W-1:0]     SLOT_LENGTH_RST  = 16'd5;
   localparam logic [CFG_W-1:0]     FRAME_PERIOD_RST = 16'd30;

   // One table entry or log record.
   typedef struct packed {
      logic [ID_W-1:0]   sensor;
      logic [TIME_W-1:0] t_begin;
      logic [TIME_W-1:0] t_end;
   } slot_rec_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic scan_start;
      logic scan_run;
      logic exec;
      logic frame_clear;
      logic log_start;
      logic log_read;
      logic log_latch;
      logic put;
      logic log_next;
      logic div_start;
      logic div_run;
      logic frame_end;
      logic out_load;
   } dp_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [ACT_W-1:0] action;
      logic             scan_done;
      logic             log_empty;
      logic             log_last;
      logic             need_catch;
      logic             div_done;
   } dp_stat_type;

endpackage

// ----- rtl/tsa_if.sv -----
// ----------------------------------------------------------------------------
// TDMA slot allocator channels
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
interface tsa_req_if import tsa_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [ACT_W-1:0]  action;
   logic [ID_W-1:0]   sensor_code;
   logic [TIME_W-1:0] current_time;

   modport source (output valid, action, sensor_code, current_time, input ready);
   modport sink   (input valid, action, sensor_code, current_time, output ready);
endinterface

interface tsa_rsp_if import tsa_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [TIME_W-1:0] slot_start;
   logic [TIME_W-1:0] slot_end;
   logic [STAT_W-1:0] status;

   modport source (output valid, slot_start, slot_end, status, input ready);
   modport sink   (input valid, slot_start, slot_end, status, output ready);
endinterface

// ----- rtl/tsa_ctrl.sv -----
// ----------------------------------------------------------------------------
// TDMA slot allocator controller
// Sequences table scans, log replay, the catch-up remainder and the result
// handshake; drives the datapath by commands only.
// ----------------------------------------------------------------------------
module tsa_ctrl import tsa_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic [ACT_W-1:0] req_action,
   output logic             req_ready,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   input  dp_stat_type      stat,
   output dp_cmd_type       cmd
);

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_SCAN = 4'd1;
   localparam logic [3:0] S_EXEC = 4'd2;
   localparam logic [3:0] S_FCLR = 4'd3;
   localparam logic [3:0] S_LRD  = 4'd4;
   localparam logic [3:0] S_LLAT = 4'd5;
   localparam logic [3:0] S_PUT  = 4'd6;
   localparam logic [3:0] S_CHK  = 4'd7;
   localparam logic [3:0] S_DIV  = 4'd8;
   localparam logic [3:0] S_FEND = 4'd9;
   localparam logic [3:0] S_DONE = 4'd10;

   logic [3:0] state_ff;
   logic [3:0] state_in;
   logic       rsp_valid_ff;

   // Next state and commands.
   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      req_ready = (state_ff == S_IDLE);
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               unique case (req_action) inside
                  ACT_REQUEST, ACT_REMOVE: begin
                     cmd.scan_start = 1'b1;
                     state_in       = S_SCAN;
                  end
                  ACT_FRAME: state_in = S_FCLR;
                  default:   state_in = S_EXEC;
               endcase
            end
         end
         S_SCAN: begin
            cmd.scan_run = 1'b1;
            if (stat.scan_done) begin
               state_in = (stat.action == ACT_FRAME) ? S_PUT : S_EXEC;
            end
         end
         S_EXEC: begin
            cmd.exec = 1'b1;
            state_in = S_DONE;
         end
         S_FCLR: begin
            cmd.frame_clear = 1'b1;
            cmd.log_start   = 1'b1;
            state_in        = stat.log_empty ? S_CHK : S_LRD;
         end
         S_LRD: begin
            cmd.log_read = 1'b1;
            state_in     = S_LLAT;
         end
         S_LLAT: begin
            cmd.log_latch  = 1'b1;
            cmd.scan_start = 1'b1;
            state_in       = S_SCAN;
         end
         S_PUT: begin
            cmd.put = 1'b1;
            if (stat.log_last) begin
               state_in = S_CHK;
            end else begin
               cmd.log_next = 1'b1;
               state_in     = S_LRD;
            end
         end
         S_CHK: begin
            if (stat.need_catch) begin
               cmd.div_start = 1'b1;
               state_in      = S_DIV;
            end else begin
               state_in = S_FEND;
            end
         end
         S_DIV: begin
            cmd.div_run = 1'b1;
            if (stat.div_done) begin
               state_in = S_FEND;
            end
         end
         S_FEND: begin
            cmd.frame_end = 1'b1;
            state_in      = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // State and result-valid registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ----- rtl/tsa_dp.sv -----
// ----------------------------------------------------------------------------
// TDMA slot allocator datapath
// Sensor table and use log memories, table scan, slot arithmetic, the
// catch-up remainder unit and the result register.
// ----------------------------------------------------------------------------
module tsa_dp import tsa_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  dp_cmd_type           cmd,
   output dp_stat_type          stat,
   input  logic [ACT_W-1:0]     in_action,
   input  logic [ID_W-1:0]      in_sensor_code,
   input  logic [TIME_W-1:0]    in_current_time,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata,
   output logic [TIME_W-1:0]    out_slot_start,
   output logic [TIME_W-1:0]    out_slot_end,
   output logic [STAT_W-1:0]    out_status
);

   // Configuration and item registers.
   logic [CFG_W-1:0]  slot_len_ff;
   logic [CFG_W-1:0]  frame_per_ff;
   logic [ACT_W-1:0]  action_ff;
   logic [ID_W-1:0]   key_ff;
   logic [TIME_W-1:0] now_ff;
   logic [TIME_W-1:0] nft_ff;

   // Table storage.
   logic [TABLE_ENTRIES-1:0] valid_ff;
   slot_rec_type             tab_mem [TABLE_ENTRIES];
   slot_rec_type             tab_rd_ff;
   logic                     tab_we;
   logic [TAB_AW-1:0]        tab_waddr;
   slot_rec_type             tab_wdata;

   // Log storage.
   slot_rec_type      log_mem [LOG_ENTRIES];
   slot_rec_type      log_rd_ff;
   logic [LOG_CW-1:0] use_count_ff;
   logic [LOG_AW-1:0] log_idx_ff;
   logic              log_full;
   logic              log_we;
   slot_rec_type      log_wdata;

   // Scan state.
   logic [TAB_CW-1:0] cnt_ff;
   logic              chk_ff;
   logic [TAB_AW-1:0] chk_idx_ff;
   logic              hit_ff;
   logic [TAB_AW-1:0] hit_idx_ff;
   logic [TIME_W-1:0] hit_begin_ff;
   logic [TIME_W-1:0] hit_end_ff;
   logic              free_ff;
   logic [TAB_AW-1:0] free_idx_ff;

   // Frame replay state.
   logic [TIME_W-1:0] put_begin_ff;
   logic [TIME_W-1:0] put_end_ff;
   logic              stat_acc_ff;
   logic [TIME_W-1:0] shift_end;

   // Remainder unit.
   logic [CFG_W-1:0]  div_rem_ff;
   logic [TIME_W-1:0] div_num_ff;
   logic [DIV_CW-1:0] div_cnt_ff;
   logic [CFG_W:0]    div_shift;
   logic [CFG_W:0]    div_sub;
   logic [TIME_W-1:0] catch_pad;

   // Result registers.
   logic [TIME_W-1:0] res_begin_ff;
   logic [TIME_W-1:0] res_end_ff;
   logic [STAT_W-1:0] res_status_ff;
   logic [TIME_W-1:0] out_begin_ff;
   logic [TIME_W-1:0] out_end_ff;
   logic [STAT_W-1:0] out_status_ff;

   logic [TIME_W-1:0] new_end;
   logic [TIME_W-1:0] log_end;
   logic              is_req;

   assign is_req    = (action_ff == ACT_REQUEST);
   assign new_end   = nft_ff + TIME_W'(slot_len_ff);
   assign log_end   = now_ff + TIME_W'(slot_len_ff);
   assign log_full  = (use_count_ff == LOG_CW'(LOG_ENTRIES));
   assign shift_end = log_rd_ff.t_end + TIME_W'(frame_per_ff);

   // Status to the controller.
   assign stat.action     = action_ff;
   assign stat.scan_done  = (cnt_ff == TAB_CW'(TABLE_ENTRIES)) && !chk_ff;
   assign stat.log_empty  = (use_count_ff == '0);
   assign stat.log_last   = (log_idx_ff == '0);
   assign stat.need_catch = (nft_ff < now_ff) && (frame_per_ff != '0);
   assign stat.div_done   = (div_cnt_ff == DIV_CW'(DIV_STEPS));

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         slot_len_ff  <= SLOT_LENGTH_RST;
         frame_per_ff <= FRAME_PERIOD_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_SLOT_LENGTH:  slot_len_ff  <= csr_wdata;
            CSR_FRAME_PERIOD: frame_per_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Item capture; the key is later replaced by each replayed log record.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         action_ff <= in_action;
         key_ff    <= in_sensor_code;
         now_ff    <= in_current_time;
      end else if (cmd.log_latch) begin
         key_ff <= log_rd_ff.sensor;
      end
   end

   // Table write port: a new sensor on request, or a replayed record.
   always_comb begin
      tab_we    = 1'b0;
      tab_waddr = free_idx_ff;
      tab_wdata = slot_rec_type'{sensor: key_ff, t_begin: nft_ff, t_end: new_end};
      if (cmd.exec && is_req && !hit_ff && free_ff) begin
         tab_we = 1'b1;
      end else if (cmd.put && (hit_ff || free_ff)) begin
         tab_we    = 1'b1;
         tab_waddr = hit_ff ? hit_idx_ff : free_idx_ff;
         tab_wdata = slot_rec_type'{sensor: key_ff, t_begin: put_begin_ff,
                                    t_end: put_end_ff};
      end
   end

   // Table memory: one write port, one registered read port for the scan.
   always_ff @(posedge clock) begin
      if (tab_we) begin
         tab_mem[tab_waddr] <= tab_wdata;
      end
      tab_rd_ff <= tab_mem[cnt_ff[TAB_AW-1:0]];
   end

   // Entry valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (cmd.frame_clear) begin
         valid_ff <= '0;
      end else if (tab_we) begin
         valid_ff[tab_waddr] <= 1'b1;
      end else if (cmd.exec && (action_ff == ACT_REMOVE) && hit_ff) begin
         valid_ff[hit_idx_ff] <= 1'b0;
      end
   end

   // Table scan: one entry per cycle, remembering the first match and the
   // first free entry.
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= TAB_CW'(TABLE_ENTRIES);
         chk_ff  <= 1'b0;
         hit_ff  <= 1'b0;
         free_ff <= 1'b0;
      end else if (cmd.scan_start) begin
         cnt_ff  <= '0;
         chk_ff  <= 1'b0;
         hit_ff  <= 1'b0;
         free_ff <= 1'b0;
      end else if (cmd.scan_run) begin
         if (cnt_ff != TAB_CW'(TABLE_ENTRIES)) begin
            cnt_ff     <= cnt_ff + 1'b1;
            chk_ff     <= 1'b1;
            chk_idx_ff <= cnt_ff[TAB_AW-1:0];
         end else begin
            chk_ff <= 1'b0;
         end
         if (chk_ff) begin
            if (valid_ff[chk_idx_ff] && (tab_rd_ff.sensor == key_ff) && !hit_ff) begin
               hit_ff       <= 1'b1;
               hit_idx_ff   <= chk_idx_ff;
               hit_begin_ff <= tab_rd_ff.t_begin;
               hit_end_ff   <= tab_rd_ff.t_end;
            end
            if (!valid_ff[chk_idx_ff] && !free_ff) begin
               free_ff     <= 1'b1;
               free_idx_ff <= chk_idx_ff;
            end
         end
      end
   end

   // Log append on request.
   assign log_we    = cmd.exec && is_req && !log_full;
   assign log_wdata = hit_ff
      ? slot_rec_type'{sensor: key_ff, t_begin: hit_begin_ff, t_end: hit_end_ff}
      : slot_rec_type'{sensor: key_ff, t_begin: now_ff, t_end: log_end};

   // Log memory: written at the fill count, read at the replay index.
   always_ff @(posedge clock) begin
      if (log_we) begin
         log_mem[use_count_ff[LOG_AW-1:0]] <= log_wdata;
      end
      if (cmd.log_read) begin
         log_rd_ff <= log_mem[log_idx_ff];
      end
   end

   // Log fill count and replay index, newest record first.
   always_ff @(posedge clock) begin
      if (reset) begin
         use_count_ff <= '0;
      end else if (cmd.frame_end) begin
         use_count_ff <= '0;
      end else if (log_we) begin
         use_count_ff <= use_count_ff + 1'b1;
      end
      if (cmd.log_start) begin
         log_idx_ff <= LOG_AW'(use_count_ff - 1'b1);
      end else if (cmd.log_next) begin
         log_idx_ff <= log_idx_ff - 1'b1;
      end
   end

   // Replayed record shifted by one frame period.
   always_ff @(posedge clock) begin
      if (cmd.log_latch) begin
         put_begin_ff <= log_rd_ff.t_begin + TIME_W'(frame_per_ff);
         put_end_ff   <= shift_end;
      end
      if (cmd.frame_clear) begin
         stat_acc_ff <= 1'b0;
      end else if (cmd.put && !hit_ff && !free_ff) begin
         stat_acc_ff <= 1'b1;
      end
   end

   // Remainder of (current time - next free time) by the frame period.
   assign div_shift = {div_rem_ff, div_num_ff[TIME_W-1]};
   assign div_sub   = div_shift - {1'b0, frame_per_ff};
   assign catch_pad = (div_rem_ff == '0) ? '0 : TIME_W'(frame_per_ff - div_rem_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         div_cnt_ff <= DIV_CW'(DIV_STEPS);
      end else if (cmd.div_start) begin
         div_num_ff <= now_ff - nft_ff;
         div_rem_ff <= '0;
         div_cnt_ff <= '0;
      end else if (cmd.div_run && !stat.div_done) begin
         div_num_ff <= {div_num_ff[TIME_W-2:0], 1'b0};
         div_rem_ff <= (div_shift >= {1'b0, frame_per_ff}) ? div_sub[CFG_W-1:0]
                                                          : div_shift[CFG_W-1:0];
         div_cnt_ff <= div_cnt_ff + 1'b1;
      end
   end

   // Next free time.
   always_ff @(posedge clock) begin
      if (reset) begin
         nft_ff <= '0;
      end else if (cmd.exec && is_req && !hit_ff) begin
         nft_ff <= new_end;
      end else if (cmd.log_latch && (shift_end > nft_ff)) begin
         nft_ff <= shift_end;
      end else if (cmd.frame_end && stat.need_catch) begin
         nft_ff <= now_ff + catch_pad;
      end
   end

   // Result of the finished item.
   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         res_begin_ff  <= '0;
         res_end_ff    <= '0;
         res_status_ff <= STAT_OK;
         case (action_ff)
            ACT_REQUEST: begin
               res_begin_ff <= hit_ff ? hit_begin_ff : nft_ff;
               res_end_ff   <= hit_ff ? hit_end_ff : new_end;
               if (!hit_ff && !free_ff) begin
                  res_status_ff <= STAT_TABLE_FULL;
               end else if (log_full) begin
                  res_status_ff <= STAT_LOG_FULL;
               end
            end
            ACT_REMOVE: begin
               if (!hit_ff) begin
                  res_status_ff <= STAT_NOT_FOUND;
               end
            end
            default: ;
         endcase
      end else if (cmd.frame_end) begin
         res_begin_ff  <= '0;
         res_end_ff    <= '0;
         res_status_ff <= stat_acc_ff ? STAT_TABLE_FULL : STAT_OK;
      end
   end

   // Output register, held while the result waits for transfer.
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_begin_ff  <= res_begin_ff;
         out_end_ff    <= res_end_ff;
         out_status_ff <= res_status_ff;
      end
   end

   assign out_slot_start = out_begin_ff;
   assign out_slot_end   = out_end_ff;
   assign out_status     = out_status_ff;

endmodule

// ----- rtl/tdma_slot_allocator.sv -----
// ----------------------------------------------------------------------------
// TDMA slot allocator
// Maps sensor ids to granted time slots, logs the slots used in a frame and
// rebuilds the map from the log at each frame update.
//
//   channel  direction  payload                               transfer when
//   req_if   in         action, sensor_code, current_time     valid && ready
//   rsp_if   out        slot_start, slot_end, status          valid && ready
//   csr_*    in         csr_index, csr_wdata                  csr_we
//
// A request or remove searches the table one entry per cycle through its single
// memory read port, and the next item is taken only once its result is loaded.
// A frame update rescans the table for each log record, then finds the catch-up
// remainder one bit a cycle when the next free time must catch up.
// Reset clears the valid bits at once; there is no clearing pass.
// One result register parts the sides: the next item is taken while a
// result waits, and a finished item waits for that register.
// ----------------------------------------------------------------------------
module tdma_slot_allocator import tsa_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   tsa_req_if.sink              req_if,
   tsa_rsp_if.source            rsp_if,
   input  logic                 csr_we,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CFG_W-1:0]     csr_wdata
);

   dp_cmd_type  cmd;
   dp_stat_type stat;

   // Sequencing and handshakes.
   tsa_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_if.valid),
      .req_action (req_if.action),
      .req_ready  (req_if.ready),
      .rsp_valid  (rsp_if.valid),
      .rsp_ready  (rsp_if.ready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // Storage and arithmetic.
   tsa_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .in_action       (req_if.action),
      .in_sensor_code  (req_if.sensor_code),
      .in_current_time (req_if.current_time),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .out_slot_start  (rsp_if.slot_start),
      .out_slot_end    (rsp_if.slot_end),
      .out_status      (rsp_if.status)
   );

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// TDMA slot allocator testbench
// Drives slot requests, sensor removals and frame updates through the
// request channel, and checks every result against a cycle-free model of the
// sensor table, the frame log and the next free time. A directed table comes
// first, then random traffic under several register settings and idling mixes.
// ----------------------------------------------------------------------------
module testbench import tsa_pkg::*; ();

   localparam logic [ACT_W-1:0] ACT_UNUSED = 2'd3;
   localparam int STALL_LIMIT = 40000;
   localparam logic [ID_W-1:0] ID_ALL = {ID_W{1'b1}};

   typedef struct packed {
      logic [TIME_W-1:0] slot_start;
      logic [TIME_W-1:0] slot_end;
      logic [STAT_W-1:0] status;
   } grant_type;

   typedef struct {
      logic [ACT_W-1:0]  action;
      logic [ID_W-1:0]   sensor_code;
      logic [TIME_W-1:0] now;
      bit                typed;
      grant_type         grant;
   } directed_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CFG_W-1:0] csr_wdata = '0;

   tsa_req_if req_if ();
   tsa_rsp_if rsp_if ();

   tdma_slot_allocator dut (
      .clock(clock), .reset(reset), .req_if(req_if), .rsp_if(rsp_if),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #5 clock = ~clock;

   // Model state: sensor table, frame log, next free time, registers.
   bit                sensor_valid [TABLE_ENTRIES];
   logic [ID_W-1:0]   sensor_key   [TABLE_ENTRIES];
   logic [TIME_W-1:0] sensor_begin [TABLE_ENTRIES];
   logic [TIME_W-1:0] sensor_end   [TABLE_ENTRIES];
   logic [ID_W-1:0]   used_key     [LOG_ENTRIES];
   logic [TIME_W-1:0] used_begin   [LOG_ENTRIES];
   logic [TIME_W-1:0] used_end     [LOG_ENTRIES];
   int                used_count;
   logic [TIME_W-1:0] free_time;
   logic [CFG_W-1:0]  slot_len;
   logic [CFG_W-1:0]  frame_len;

   grant_type pending_grants[$];
   int error_count = 0;
   int items_sent = 0;
   int grants_checked = 0;
   int frames_sent = 0;
   int full_seen = 0;
   int sender_idle_pct = 0;
   int receiver_idle_pct = 0;
   int holdoff_cycles = 0;
   int quiet_cycles = 0;
   logic [TIME_W-1:0] wall_time = '0;
   logic [ID_W-1:0] sensor_pool[16];

   function automatic int find_sensor(logic [ID_W-1:0] id);
      for (int i = 0; i < TABLE_ENTRIES; i++)
         if (sensor_valid[i] && sensor_key[i] == id) return i;
      return -1;
   endfunction

   function automatic bit install_sensor(logic [ID_W-1:0] id, logic [TIME_W-1:0] b,
                                         logic [TIME_W-1:0] e);
      int i;
      i = find_sensor(id);
      if (i < 0) begin
         for (i = 0; i < TABLE_ENTRIES; i++)
            if (!sensor_valid[i]) break;
         if (i >= TABLE_ENTRIES) return 1'b0;
      end
      sensor_valid[i] = 1'b1;
      sensor_key[i] = id;
      sensor_begin[i] = b;
      sensor_end[i] = e;
      return 1'b1;
   endfunction

   function automatic bit record_use(logic [ID_W-1:0] id, logic [TIME_W-1:0] b,
                                     logic [TIME_W-1:0] e);
      if (used_count >= LOG_ENTRIES) return 1'b0;
      used_key[used_count] = id;
      used_begin[used_count] = b;
      used_end[used_count] = e;
      used_count++;
      return 1'b1;
   endfunction

   // Work out the grant for one accepted item and advance the model.
   function automatic grant_type allocate_slot(logic [ACT_W-1:0] action,
                                               logic [ID_W-1:0] id,
                                               logic [TIME_W-1:0] now);
      grant_type g;
      int i;
      bit tab_ok, log_ok;
      logic [TIME_W-1:0] nb, ne;
      logic [63:0] diff, steps;
      g = '0;
      g.status = STAT_OK;
      case (action)
         ACT_REQUEST: begin
            i = find_sensor(id);
            if (i >= 0) begin
               g.slot_start = sensor_begin[i];
               g.slot_end = sensor_end[i];
               if (!record_use(id, g.slot_start, g.slot_end)) g.status = STAT_LOG_FULL;
            end else begin
               g.slot_start = free_time;
               g.slot_end = free_time + slot_len;
               free_time = g.slot_end;
               tab_ok = install_sensor(id, g.slot_start, g.slot_end);
               log_ok = record_use(id, now, now + slot_len);
               if (!tab_ok) g.status = STAT_TABLE_FULL;
               else if (!log_ok) g.status = STAT_LOG_FULL;
            end
         end
         ACT_REMOVE: begin
            i = find_sensor(id);
            if (i >= 0) sensor_valid[i] = 1'b0;
            else g.status = STAT_NOT_FOUND;
         end
         ACT_FRAME: begin
            for (int k = 0; k < TABLE_ENTRIES; k++) sensor_valid[k] = 1'b0;
            // Newest first, so the oldest record of a sensor is written last.
            for (int k = used_count - 1; k >= 0; k--) begin
               nb = used_begin[k] + frame_len;
               ne = used_end[k] + frame_len;
               if (!install_sensor(used_key[k], nb, ne)) g.status = STAT_TABLE_FULL;
               if (ne > free_time) free_time = ne;
            end
            if (free_time < now && frame_len != 0) begin
               diff = 64'(now - free_time);
               steps = (diff + frame_len - 1) / frame_len;
               free_time = TIME_W'(64'(free_time) + steps * frame_len);
            end
            used_count = 0;
         end
         default: ;
      endcase
      return g;
   endfunction

   task automatic report_mismatch(string what, logic [TIME_W-1:0] got,
                                  logic [TIME_W-1:0] want);
      $display("MISMATCH %s: got %0h, expected %0h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // Offer one item from a falling edge until it is transferred.
   task automatic send_item(logic [ACT_W-1:0] action, logic [ID_W-1:0] id,
                            logic [TIME_W-1:0] now, bit typed, grant_type typed_grant);
      grant_type g;
      while ($urandom_range(0, 99) < sender_idle_pct) begin
         req_if.valid = 1'b0;
         @(negedge clock);
      end
      req_if.valid = 1'b1;
      req_if.action = action;
      req_if.sensor_code = id;
      req_if.current_time = now;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      g = allocate_slot(action, id, now);
      pending_grants.push_back(typed ? typed_grant : g);
      items_sent++;
      if (action == ACT_FRAME) frames_sent++;
      if (g.status == STAT_TABLE_FULL || g.status == STAT_LOG_FULL) full_seen++;
      @(negedge clock);
      req_if.valid = 1'b0;
   endtask

   task automatic drain();
      while (pending_grants.size() != 0) @(negedge clock);
   endtask

   // Register writes only once the block has gone quiet.
   task automatic write_regs(logic [CFG_W-1:0] len, logic [CFG_W-1:0] per);
      drain();
      repeat (10) @(negedge clock);
      csr_we = 1'b1;
      csr_index = CSR_SLOT_LENGTH;
      csr_wdata = len;
      @(negedge clock);
      csr_index = CSR_FRAME_PERIOD;
      csr_wdata = per;
      @(negedge clock);
      csr_we = 1'b0;
      slot_len = len;
      frame_len = per;
   endtask

   function automatic logic [ID_W-1:0] pick_sensor();
      if ($urandom_range(0, 99) < 80) return sensor_pool[$urandom_range(0, 15)];
      return ID_W'($urandom);
   endfunction

   // Random traffic; a burst of fresh sensors overflows both table and log.
   task automatic run_random(int count, bit burst);
      int r;
      logic [ACT_W-1:0] a;
      if (burst) begin
         for (int n = 0; n < 80; n++) begin
            wall_time += $urandom_range(0, 20);
            send_item(ACT_REQUEST, ID_W'($urandom), wall_time, 1'b0, '0);
         end
         send_item(ACT_FRAME, '0, wall_time, 1'b0, '0);
      end
      for (int n = 0; n < count; n++) begin
         r = $urandom_range(0, 99);
         a = (r < 8) ? ACT_FRAME : (r < 22) ? ACT_REMOVE : (r < 24) ? ACT_UNUSED
                                                                   : ACT_REQUEST;
         if ($urandom_range(0, 99) < 3) wall_time = $urandom;
         else wall_time += $urandom_range(0, 40);
         send_item(a, pick_sensor(), wall_time, 1'b0, '0);
      end
   endtask

   // Result side: random stalls plus long hold-offs on request.
   always @(negedge clock) begin
      if (holdoff_cycles > 0) begin
         holdoff_cycles--;
         rsp_if.ready = 1'b0;
      end else begin
         rsp_if.ready = ($urandom_range(0, 99) >= receiver_idle_pct);
      end
   end

   // Check each transferred result against the oldest pending grant.
   always @(posedge clock) begin
      grant_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_grants.size() == 0) begin
            report_mismatch("unexpected result", TIME_W'(rsp_if.status), '0);
         end else begin
            want = pending_grants.pop_front();
            grants_checked++;
            if (rsp_if.slot_start !== want.slot_start)
               report_mismatch("slot_start", rsp_if.slot_start, want.slot_start);
            if (rsp_if.slot_end !== want.slot_end)
               report_mismatch("slot_end", rsp_if.slot_end, want.slot_end);
            if (rsp_if.status !== want.status)
               report_mismatch("status", TIME_W'(rsp_if.status), TIME_W'(want.status));
         end
      end
   end

   // Watchdog on cycles with no transfer on either channel.
   always @(posedge clock) begin
      if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) || reset)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > STALL_LIMIT) begin
         $display("Watchdog: no transfer for %0d cycles", quiet_cycles);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   directed_row_type directed_rows[$];

   function automatic grant_type mk(logic [TIME_W-1:0] b, logic [TIME_W-1:0] e,
                                    logic [STAT_W-1:0] s);
      grant_type g;
      g.slot_start = b;
      g.slot_end = e;
      g.status = s;
      return g;
   endfunction

   initial begin
      req_if.valid = 1'b0;
      req_if.action = ACT_REQUEST;
      req_if.sensor_code = '0;
      req_if.current_time = '0;
      for (int i = 0; i < TABLE_ENTRIES; i++) sensor_valid[i] = 1'b0;
      used_count = 0;
      free_time = '0;
      slot_len = SLOT_LENGTH_RST;
      frame_len = FRAME_PERIOD_RST;
      for (int i = 0; i < 16; i++) sensor_pool[i] = ID_W'($urandom);
      sensor_pool[0] = '0;
      sensor_pool[1] = ID_ALL;

      // Directed part: extremes, every action, not-found, the unused code.
      directed_rows = '{
         '{ACT_REQUEST, '0, 32'h0, 1'b1, mk(0, 5, STAT_OK)},
         '{ACT_REQUEST, ID_ALL, 32'hFFFF_FFFF, 1'b1, mk(5, 10, STAT_OK)},
         '{ACT_REQUEST, '0, 32'd7, 1'b1, mk(0, 5, STAT_OK)},
         '{ACT_REMOVE, 27'd123, 32'd8, 1'b1, mk(0, 0, STAT_NOT_FOUND)},
         '{ACT_REMOVE, ID_ALL, 32'd9, 1'b1, mk(0, 0, STAT_OK)},
         '{ACT_UNUSED, 27'h555_5555, 32'hAAAA_AAAA, 1'b1, mk(0, 0, STAT_OK)},
         '{ACT_FRAME, '0, 32'd100, 1'b1, mk(0, 0, STAT_OK)},
         '{ACT_REQUEST, '0, 32'd120, 1'b0, mk(0, 0, STAT_OK)},
         '{ACT_REQUEST, 27'd42, 32'd130, 1'b0, mk(0, 0, STAT_OK)},
         '{ACT_REQUEST, 27'd42, 32'd131, 1'b0, mk(0, 0, STAT_OK)},
         '{ACT_FRAME, 27'h2AA_AAAA, 32'hFFFF_FFFF, 1'b0, mk(0, 0, STAT_OK)},
         '{ACT_REQUEST, 27'd42, 32'd5, 1'b0, mk(0, 0, STAT_OK)},
         '{ACT_REMOVE, 27'd42, 32'd6, 1'b0, mk(0, 0, STAT_OK)},
         '{ACT_REMOVE, 27'd42, 32'd7, 1'b0, mk(0, 0, STAT_OK)},
         '{ACT_FRAME, '0, 32'd0, 1'b0, mk(0, 0, STAT_OK)}
      };

      repeat (9) @(negedge clock);
      reset = 1'b0;

      foreach (directed_rows[i])
         send_item(directed_rows[i].action, directed_rows[i].sensor_code,
                   directed_rows[i].now, directed_rows[i].typed, directed_rows[i].grant);

      // Receiver idles more than the sender.
      sender_idle_pct = 37;
      receiver_idle_pct = 71;
      write_regs(16'd1, 16'd1);
      run_random(140, 1'b0);
      // Long hold-off while items keep coming, so the input backs up.
      holdoff_cycles = 3000;
      run_random(20, 1'b0);
      write_regs(16'hFFFF, 16'hFFFF);
      run_random(140, 1'b0);

      // Sender idles more than the receiver.
      sender_idle_pct = 71;
      receiver_idle_pct = 37;
      write_regs(16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)));
      run_random(140, 1'b1);
      drain();
      write_regs(16'd1, 16'hFFFF);
      run_random(120, 1'b0);

      // No idling on either side.
      sender_idle_pct = 0;
      receiver_idle_pct = 0;
      write_regs(16'hFFFF, 16'd1);
      run_random(100, 1'b0);
      write_regs(SLOT_LENGTH_RST, FRAME_PERIOD_RST);
      run_random(60, 1'b0);

      drain();
      repeat (200) @(negedge clock);
      $display("Covered %0d items (%0d frame updates), %0d results checked,",
               items_sent, frames_sent, grants_checked);
      $display("%0d full-table or full-log grants, six register settings after reset.",
               full_seen);
      if (error_count == 0 && pending_grants.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
